### design/lj_pkg.sv
// Shared number format, constants and helpers for the Lennard-Jones pair evaluator.
package lj_pkg;

	// Exponent width of the internal floating format.
	localparam int XW = 12;

	// Internal value: sign, 64-bit mantissa with its top bit set (or zero), exponent.
	typedef struct packed {
		logic                 neg;
		logic [63:0]          m;
		logic signed [XW-1:0] e;
	} xval_t;

	localparam xval_t X_ZERO = '{neg: 1'b0, m: 64'd0, e: '0};
	localparam xval_t X_K7   = '{neg: 1'b0, m: 64'hE000_0000_0000_0000, e: XW'(-61)};
	localparam xval_t X_K12  = '{neg: 1'b0, m: 64'hC000_0000_0000_0000, e: XW'(-60)};
	localparam xval_t X_K13  = '{neg: 1'b0, m: 64'hD000_0000_0000_0000, e: XW'(-60)};

	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// Pipeline depths of the arithmetic units.
	localparam int MUL_LAT    = 2;
	localparam int ADD_LAT    = 3;
	localparam int DIV_STEPS  = 5;
	localparam int DIV_STAGES = 95 / DIV_STEPS;
	localparam int RCP_LAT    = DIV_STAGES + 3;
	// Reciprocal, longest arithmetic path (curvature) and the output conversion.
	localparam int CTL_LAT    = RCP_LAT + 6 * MUL_LAT + ADD_LAT + 4 * MUL_LAT + 1;

	typedef enum logic [2:0] {
		CFG_CUTOFF  = 3'd0,
		CFG_ESCALE  = 3'd1,
		CFG_FSCALE  = 3'd2,
		CFG_REPULS  = 3'd3,
		CFG_ATTR_E  = 3'd4,
		CFG_ATTR_F  = 3'd5
	} cfg_idx_t;

	// Count of leading zeros; 64 for an all-zero word.
	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 7'(63 - i);
			end
		end
		return n;
	endfunction

endpackage

### design/lj_dly.sv
// Fixed-length delay line used to align operands between arithmetic units.
module lj_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [0:D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				tap_q[i] <= '0;
			end
		end else begin
			tap_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[D-1];

endmodule

### design/lj_recip.sv
// Pipelined reciprocal of the Q8.24 distance, giving a normalized internal value.
module lj_recip import lj_pkg::*; (
	input  logic        clk,
	input  logic [31:0] distance,
	output xval_t       y
);

	logic [31:0] rin;
	logic [6:0]  lz_full;
	logic [31:0] r_s1;
	logic [4:0]  lz_s1;
	logic [31:0] rn_s2;
	logic [4:0]  sh_s2;
	xval_t       res_s3;

	logic [31:0] rn_d  [0:DIV_STAGES];
	logic [31:0] rem_d [0:DIV_STAGES];
	logic [63:0] q_d   [0:DIV_STAGES];
	logic [4:0]  sh_d  [0:DIV_STAGES];

	// A zero distance is evaluated as one LSB.
	always_comb begin
		rin     = (distance == 32'd0) ? 32'd1 : distance;
		lz_full = lzc64({rin, 32'd0});
	end

	always_ff @(posedge clk) begin
		r_s1  <= rin;
		lz_s1 <= lz_full[4:0];
		rn_s2 <= r_s1 << lz_s1;
		sh_s2 <= lz_s1;
	end

	assign rn_d[0]  = rn_s2;
	assign rem_d[0] = 32'd1;
	assign q_d[0]   = 64'd0;
	assign sh_d[0]  = sh_s2;

	// Restoring division of 2^95 by the normalized distance, DIV_STEPS (five) bits per stage.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [31:0] rem_nx;
		logic [63:0] q_nx;

		always_comb begin : step
			logic [32:0] rem2;
			logic [31:0] rem;
			logic [63:0] q;
			rem = rem_d[k];
			q   = q_d[k];
			for (int j = 0; j < DIV_STEPS; j++) begin
				rem2 = {rem, 1'b0};
				if (rem2 >= {1'b0, rn_d[k]}) begin
					rem2 = rem2 - {1'b0, rn_d[k]};
					q    = {q[62:0], 1'b1};
				end else begin
					q    = {q[62:0], 1'b0};
				end
				rem = rem2[31:0];
			end
			rem_nx = rem;
			q_nx   = q;
		end

		always_ff @(posedge clk) begin
			rn_d[k+1]  <= rn_d[k];
			rem_d[k+1] <= rem_nx;
			q_d[k+1]   <= q_nx;
			sh_d[k+1]  <= sh_d[k];
		end
	end

	always_ff @(posedge clk) begin
		if (rn_d[DIV_STAGES] == 32'h8000_0000) begin
			res_s3.neg <= 1'b0;
			res_s3.m   <= Q_MIN;
			res_s3.e   <= $signed({{(XW-5){1'b0}}, sh_d[DIV_STAGES]}) - XW'(70);
		end else begin
			res_s3.neg <= 1'b0;
			res_s3.m   <= q_d[DIV_STAGES];
			res_s3.e   <= $signed({{(XW-5){1'b0}}, sh_d[DIV_STAGES]}) - XW'(71);
		end
	end

	assign y = res_s3;

endmodule

### design/lj_fmul.sv
// Two-stage multiplier for internal values: partial products, then sum and normalize.
module lj_fmul import lj_pkg::*; (
	input  logic  clk,
	input  xval_t a,
	input  xval_t b,
	output xval_t y
);

	logic [63:0]          p0_s1, p1_s1, p2_s1, p3_s1;
	logic                 neg_s1;
	logic                 zero_s1;
	logic signed [XW-1:0] e_s1;
	logic [63:0]          mid;
	logic [63:0]          lo;
	logic [63:0]          hi;
	logic signed [XW-1:0] e_n;
	xval_t                res_s2;

	always_ff @(posedge clk) begin
		p0_s1   <= a.m[31:0]  * b.m[31:0];
		p1_s1   <= a.m[31:0]  * b.m[63:32];
		p2_s1   <= a.m[63:32] * b.m[31:0];
		p3_s1   <= a.m[63:32] * b.m[63:32];
		neg_s1  <= a.neg ^ b.neg;
		zero_s1 <= (a.m == 64'd0) || (b.m == 64'd0);
		e_s1    <= a.e + b.e + XW'(64);
	end

	always_comb begin
		mid = {32'd0, p0_s1[63:32]} + {32'd0, p1_s1[31:0]} + {32'd0, p2_s1[31:0]};
		lo  = {mid[31:0], p0_s1[31:0]};
		hi  = p3_s1 + {32'd0, p1_s1[63:32]} + {32'd0, p2_s1[63:32]} + {32'd0, mid[63:32]};
		e_n = e_s1;
		if (!hi[63]) begin
			hi  = {hi[62:0], lo[63]};
			e_n = e_s1 - XW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s1) begin
			res_s2 <= X_ZERO;
		end else begin
			res_s2.neg <= neg_s1;
			res_s2.m   <= hi;
			res_s2.e   <= e_n;
		end
	end

	assign y = res_s2;

endmodule

### design/lj_fadd.sv
// Three-stage adder for internal values: align and add, count leading zeros, normalize.
module lj_fadd import lj_pkg::*; (
	input  logic  clk,
	input  xval_t a,
	input  xval_t b,
	output xval_t y
);

	xval_t                big;
	xval_t                sml;
	logic [XW:0]          dif;
	logic [63:0]          bm;
	logic [63:0]          sum;
	logic signed [XW-1:0] e_c;
	logic                 neg_c;
	logic [63:0]          s_s1, s_s2;
	logic signed [XW-1:0] e_s1, e_s2;
	logic                 neg_s1, neg_s2;
	logic [6:0]           lz_s2;
	xval_t                res_s3;

	always_comb begin
		big   = a;
		sml   = b;
		dif   = '0;
		bm    = '0;
		sum   = a.m;
		e_c   = a.e;
		neg_c = a.neg;
		if (a.m == 64'd0) begin
			sum   = b.m;
			e_c   = b.e;
			neg_c = b.neg;
		end else if (b.m != 64'd0) begin
			if ((b.e > a.e) || ((b.e == a.e) && (b.m > a.m))) begin
				big = b;
				sml = a;
			end
			dif = {big.e[XW-1], big.e} - {sml.e[XW-1], sml.e};
			bm  = (dif < (XW+1)'(63)) ? ((sml.m >> dif[5:0]) >> 1) : 64'd0;
			sum = (big.neg == sml.neg) ? ((big.m >> 1) + bm) : ((big.m >> 1) - bm);
			e_c   = big.e + XW'(1);
			neg_c = big.neg;
		end
	end

	always_ff @(posedge clk) begin
		s_s1   <= sum;
		e_s1   <= e_c;
		neg_s1 <= neg_c;
		s_s2   <= s_s1;
		e_s2   <= e_s1;
		neg_s2 <= neg_s1;
		lz_s2  <= lzc64(s_s1);
	end

	always_ff @(posedge clk) begin
		if (s_s2 == 64'd0) begin
			res_s3 <= X_ZERO;
		end else begin
			res_s3.neg <= neg_s2;
			res_s3.m   <= s_s2 << lz_s2[5:0];
			res_s3.e   <= e_s2 - $signed({{(XW-7){1'b0}}, lz_s2});
		end
	end

	assign y = res_s3;

endmodule

### design/lennard_jones_pair_eval_core.sv
// Top level of the Lennard-Jones 12-6 pair evaluator: energy, force and curvature.
//
// Usage: a distance (unsigned Q8.24) is offered with start; the transaction
// is taken at every rising edge with start high and busy low. busy is never
// raised, so one distance can be taken in every clock cycle.
// Each result transaction appears for exactly one cycle with done high, carrying
// energy, force_res and curvature (signed Q32.32, saturating), beyond_cutoff
// and saturated. Results leave in the order the distances arrived.
// Throughput is one transaction per cycle. The pipeline depth is set by the
// 19-stage divider of the reciprocal (five quotient bits per stage) and the
// chain of two-stage multipliers that forms 1/r^14 and the curvature term.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes one of six registers; an unknown index is dropped.
// Coefficients must only be written while no transaction is in flight.
// Reset clears the configuration registers, the delay lines and done to zero
// and empties the pipeline; no result appears until a distance is accepted.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module lennard_jones_pair_eval_core import lj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] distance,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [63:0] energy,
	output logic [63:0] force_res,
	output logic [63:0] curvature,
	output logic        beyond_cutoff,
	output logic        saturated
);

	// Configuration registers, raw.
	logic [31:0] cutoff_q;
	logic [63:0] escale_q, fscale_q, repuls_q, attr_e_q, attr_f_q;

	// Configuration values converted to the internal format.
	xval_t c_e, c_f, c_s12, c_ae, c_af;

	logic        take;
	logic [2:0]  ctl_in, ctl_out;

	xval_t u, u6, u8, u10, i2, i2d, i4, i6, i7, i8, i12, i13, i14;
	xval_t pe1, pe2, pe2d, pe2n, te, en, en_d;
	xval_t pf1, pf1d, pf2, pf2n, tf, fr, fr_d;
	xval_t pc1, pc2, pc3, pc4, pc4d, pc4n, tc, tc12, cv;

	logic [64:0] en_cv, fr_cv, cv_cv;
	logic [63:0] en_s, fr_s, cv_s;
	logic        sat_s;
	logic        done_q;
	logic [63:0] energy_q, force_q, curv_q;
	logic        beyond_q, sat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
			escale_q <= '0;
			fscale_q <= '0;
			repuls_q <= '0;
			attr_e_q <= '0;
			attr_f_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CUTOFF: begin
					cutoff_q <= cfg_data[31:0];
				end
				CFG_ESCALE: begin
					escale_q <= cfg_data;
				end
				CFG_FSCALE: begin
					fscale_q <= cfg_data;
				end
				CFG_REPULS: begin
					repuls_q <= cfg_data;
				end
				CFG_ATTR_E: begin
					attr_e_q <= cfg_data;
				end
				CFG_ATTR_F: begin
					attr_f_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Q32.32 to internal format: magnitude with exponent -32, normalized by
	// passing it through an adder with a zero second operand. The converted
	// values settle in the adder's registers after a write, long before any use.
	function automatic xval_t q_to_x(input logic [63:0] raw);
		xval_t x;
		x.neg = raw[63];
		x.m   = raw[63] ? (~raw + 64'd1) : raw;
		x.e   = XW'(-32);
		return x;
	endfunction

	function automatic xval_t x_neg(input xval_t x);
		xval_t r;
		r     = x;
		r.neg = ~x.neg;
		return r;
	endfunction

	// Internal format to Q32.32 with truncation toward zero; the top bit says clipped.
	function automatic logic [64:0] x_to_q(input xval_t x);
		logic signed [XW-1:0] k;
		logic [XW-1:0]        sh;
		logic [63:0]          mag;
		logic [64:0]          r;
		k   = x.e + XW'(32);
		sh  = -k;
		mag = '0;
		r   = '0;
		if (x.m == 64'd0) begin
			r = '0;
		end else if (!k[XW-1]) begin
			if ((k == '0) && x.neg && (x.m == Q_MIN)) begin
				r = {1'b0, Q_MIN};
			end else begin
				r = {1'b1, x.neg ? Q_MIN : Q_MAX};
			end
		end else begin
			mag = (sh >= XW'(64)) ? 64'd0 : (x.m >> sh[5:0]);
			r   = {1'b0, x.neg ? (64'd0 - mag) : mag};
		end
		return r;
	endfunction

	lj_fadd u_cv_e   (.clk(clk), .a(q_to_x(escale_q)), .b(X_ZERO), .y(c_e));
	lj_fadd u_cv_f   (.clk(clk), .a(q_to_x(fscale_q)), .b(X_ZERO), .y(c_f));
	lj_fadd u_cv_s12 (.clk(clk), .a(q_to_x(repuls_q)), .b(X_ZERO), .y(c_s12));
	lj_fadd u_cv_ae  (.clk(clk), .a(q_to_x(attr_e_q)), .b(X_ZERO), .y(c_ae));
	lj_fadd u_cv_af  (.clk(clk), .a(q_to_x(attr_f_q)), .b(X_ZERO), .y(c_af));

	// Control travels beside the data: valid, beyond cutoff, zero distance.
	assign ctl_in = {take, (distance > cutoff_q), (distance == 32'd0)};

	lj_dly #(.W(3), .D(CTL_LAT)) u_ctl (
		.clk(clk), .arst_n(arst_n), .d(ctl_in), .q(ctl_out)
	);

	// Reciprocal and the powers of 1/r.
	lj_recip u_rcp (.clk(clk), .distance(distance), .y(u));

	lj_dly #(.W($bits(xval_t)), .D(6)) u_d_u6  (.clk(clk), .arst_n(arst_n), .d(u),   .q(u6));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_u8  (.clk(clk), .arst_n(arst_n), .d(u6),  .q(u8));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_u10 (.clk(clk), .arst_n(arst_n), .d(u8),  .q(u10));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_i2  (.clk(clk), .arst_n(arst_n), .d(i2),  .q(i2d));

	lj_fmul u_m_i2  (.clk(clk), .a(u),   .b(u),   .y(i2));
	lj_fmul u_m_i4  (.clk(clk), .a(i2),  .b(i2),  .y(i4));
	lj_fmul u_m_i6  (.clk(clk), .a(i4),  .b(i2d), .y(i6));
	lj_fmul u_m_i7  (.clk(clk), .a(i6),  .b(u6),  .y(i7));
	lj_fmul u_m_i12 (.clk(clk), .a(i6),  .b(i6),  .y(i12));
	lj_fmul u_m_i8  (.clk(clk), .a(i7),  .b(u8),  .y(i8));
	lj_fmul u_m_i13 (.clk(clk), .a(i12), .b(u8),  .y(i13));
	lj_fmul u_m_i14 (.clk(clk), .a(i13), .b(u10), .y(i14));

	// Energy: E * (S12 / r^12 - AE / r^6).
	lj_fmul u_m_pe1 (.clk(clk), .a(c_s12), .b(i12), .y(pe1));
	lj_fmul u_m_pe2 (.clk(clk), .a(c_ae),  .b(i6),  .y(pe2));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_pe2 (.clk(clk), .arst_n(arst_n), .d(pe2), .q(pe2d));
	assign pe2n = x_neg(pe2d);
	lj_fadd u_a_e   (.clk(clk), .a(pe1), .b(pe2n), .y(te));
	lj_fmul u_m_e   (.clk(clk), .a(c_e), .b(te),   .y(en));
	lj_dly #(.W($bits(xval_t)), .D(8)) u_d_en (.clk(clk), .arst_n(arst_n), .d(en), .q(en_d));

	// Force: F * (AF / r^7 - S12 / r^13).
	lj_fmul u_m_pf1 (.clk(clk), .a(c_af),  .b(i7),  .y(pf1));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_pf1 (.clk(clk), .arst_n(arst_n), .d(pf1), .q(pf1d));
	lj_fmul u_m_pf2 (.clk(clk), .a(c_s12), .b(i13), .y(pf2));
	assign pf2n = x_neg(pf2);
	lj_fadd u_a_f   (.clk(clk), .a(pf1d), .b(pf2n), .y(tf));
	lj_fmul u_m_f   (.clk(clk), .a(c_f),  .b(tf),   .y(fr));
	lj_dly #(.W($bits(xval_t)), .D(6)) u_d_fr (.clk(clk), .arst_n(arst_n), .d(fr), .q(fr_d));

	// Curvature: ((S12/r^14 * 13 - AF/r^8 * 7) * 12) * E.
	lj_fmul u_m_pc1 (.clk(clk), .a(c_s12), .b(i14),   .y(pc1));
	lj_fmul u_m_pc2 (.clk(clk), .a(pc1),   .b(X_K13), .y(pc2));
	lj_fmul u_m_pc3 (.clk(clk), .a(c_af),  .b(i8),    .y(pc3));
	lj_fmul u_m_pc4 (.clk(clk), .a(pc3),   .b(X_K7),  .y(pc4));
	lj_dly #(.W($bits(xval_t)), .D(2)) u_d_pc4 (.clk(clk), .arst_n(arst_n), .d(pc4), .q(pc4d));
	assign pc4n = x_neg(pc4d);
	lj_fadd u_a_c   (.clk(clk), .a(pc2),  .b(pc4n),  .y(tc));
	lj_fmul u_m_c12 (.clk(clk), .a(tc),   .b(X_K12), .y(tc12));
	lj_fmul u_m_c   (.clk(clk), .a(tc12), .b(c_e),   .y(cv));

	// Conversion to Q32.32, one register stage.
	always_comb begin
		en_cv = x_to_q(en_d);
		fr_cv = x_to_q(fr_d);
		cv_cv = x_to_q(cv);
	end

	always_ff @(posedge clk) begin
		en_s  <= en_cv[63:0];
		fr_s  <= fr_cv[63:0];
		cv_s  <= cv_cv[63:0];
		sat_s <= en_cv[64] | fr_cv[64] | cv_cv[64];
	end

	// Output register: beyond cutoff forces zeros; a zero distance forces saturated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_out[2];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_out[1]) begin
			energy_q <= '0;
			force_q  <= '0;
			curv_q   <= '0;
			beyond_q <= 1'b1;
			sat_q    <= 1'b0;
		end else begin
			energy_q <= en_s;
			force_q  <= fr_s;
			curv_q   <= cv_s;
			beyond_q <= 1'b0;
			sat_q    <= sat_s | ctl_out[0];
		end
	end

	assign done          = done_q;
	assign energy        = energy_q;
	assign force_res     = force_q;
	assign curvature     = curv_q;
	assign beyond_cutoff = beyond_q;
	assign saturated     = sat_q;

endmodule

### bench/tb_lennard_jones_pair_eval_core.sv
// Self-checking testbench for the Lennard-Jones pair evaluator core.
module tb_lennard_jones_pair_eval_core import lj_pkg::*;;

	// Cycles without any accepted transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Fixed latency of the core plus some margin, used for the final drain.
	localparam int DRAIN_CYCLES = 60;
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
	localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] distance = '0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [63:0] energy;
	logic [63:0] force_res;
	logic [63:0] curvature;
	logic        beyond_cutoff;
	logic        saturated;

	// Extended-precision value used by the predictor: sign, normalized
	// 64-bit mantissa and an unbounded exponent.
	typedef struct {
		bit        neg;
		bit [63:0] m;
		int        e;
	} ext_t;

	typedef struct {
		bit [63:0] energy;
		bit [63:0] force_res;
		bit [63:0] curvature;
		bit        beyond;
		bit        sat;
	} pair_result_t;

	// Shadow copy of the coefficient registers.
	bit [31:0] cut_r;
	bit [63:0] coef_e, coef_f, coef_s12, coef_ae, coef_af;

	pair_result_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;

	lennard_jones_pair_eval_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .distance(distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .energy(energy), .force_res(force_res),
		.curvature(curvature), .beyond_cutoff(beyond_cutoff), .saturated(saturated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor arithmetic. Every step truncates exactly as the core's
	// datapath is specified to, so results must match bit for bit.
	// ---------------------------------------------------------------
	function automatic ext_t ext_norm(bit neg, bit [63:0] m, int e);
		ext_t r;
		if (m == 0) begin
			r.neg = 0; r.m = 0; r.e = 0;
			return r;
		end
		while (!m[63]) begin
			m = m << 1;
			e--;
		end
		r.neg = neg; r.m = m; r.e = e;
		return r;
	endfunction

	// Signed Q32.32 register value into the extended format.
	function automatic ext_t ext_from_q32(bit [63:0] raw);
		bit [63:0] mag;
		mag = raw[63] ? (~raw + 64'd1) : raw;
		return ext_norm(raw[63], mag, -32);
	endfunction

	// Mantissa product keeps the top 64 bits, with one bit of renormalization.
	function automatic ext_t ext_mul(ext_t a, ext_t b);
		bit [127:0] p;
		bit [63:0]  hi;
		int         e;
		if (a.m == 0 || b.m == 0) return ext_norm(0, 0, 0);
		p = {64'd0, a.m} * {64'd0, b.m};
		hi = p[127:64];
		e = a.e + b.e + 64;
		if (!hi[63]) begin
			hi = {hi[62:0], p[63]};
			e--;
		end
		return ext_norm(a.neg ^ b.neg, hi, e);
	endfunction

	function automatic ext_t ext_neg(ext_t a);
		if (a.m != 0) a.neg = ~a.neg;
		return a;
	endfunction

	// Alignment drops one guard bit off the larger operand and shifts the
	// smaller one right by the exponent gap plus one.
	function automatic ext_t ext_add(ext_t a, ext_t b);
		ext_t      t;
		int        d;
		bit [63:0] am, bm, s;
		if (a.m == 0) return b;
		if (b.m == 0) return a;
		if (b.e > a.e || (b.e == a.e && b.m > a.m)) begin
			t = a; a = b; b = t;
		end
		d = a.e - b.e;
		am = a.m >> 1;
		bm = (d < 63) ? (b.m >> (d + 1)) : 64'd0;
		s = (a.neg == b.neg) ? (am + bm) : (am - bm);
		return ext_norm(a.neg, s, a.e + 1);
	endfunction

	// Reciprocal of a nonzero Q8.24 distance; a power of two is exact.
	function automatic ext_t ext_recip(bit [31:0] r);
		bit [63:0]  rn;
		bit [127:0] q;
		int         s;
		rn = {32'd0, r};
		s = 0;
		while (!rn[31]) begin
			rn = rn << 1;
			s++;
		end
		if (rn == 64'h8000_0000) return ext_norm(0, 64'h8000_0000_0000_0000, s - 70);
		q = (128'd1 << 95) / {64'd0, rn};
		return ext_norm(0, q[63:0], s - 71);
	endfunction

	// Truncation toward zero into Q32.32 with clipping to the signed range.
	function automatic bit [63:0] ext_to_q32(ext_t x, inout bit sat);
		int        k;
		bit [63:0] mag;
		if (x.m == 0) return 64'd0;
		k = x.e + 32;
		if (k >= 0) begin
			if (k == 0 && x.neg && x.m == Q_MIN) return Q_MIN;
			sat = 1;
			return x.neg ? Q_MIN : Q_MAX;
		end
		mag = (k <= -64) ? 64'd0 : (x.m >> (-k));
		return x.neg ? (64'd0 - mag) : mag;
	endfunction

	// Energy, force and curvature for one separation under the current
	// coefficient set.
	function automatic pair_result_t lj_pair_eval(bit [31:0] sep);
		pair_result_t res;
		ext_t u, i2, i4, i6, i7, i8, i12, i13, i14;
		ext_t ee, ff, s12, ae, af, t;
		bit   sat;
		bit [31:0] r;
		res = '{default: '0};
		if (sep > cut_r) begin
			res.beyond = 1;
			return res;
		end
		r = sep;
		sat = 0;
		// A zero separation is evaluated at one LSB and always flagged.
		if (r == 0) begin
			sat = 1;
			r = 32'd1;
		end
		u = ext_recip(r);
		i2 = ext_mul(u, u);
		i4 = ext_mul(i2, i2);
		i6 = ext_mul(i4, i2);
		i7 = ext_mul(i6, u);
		i8 = ext_mul(i7, u);
		i12 = ext_mul(i6, i6);
		i13 = ext_mul(i12, u);
		i14 = ext_mul(i13, u);
		ee = ext_from_q32(coef_e);
		ff = ext_from_q32(coef_f);
		s12 = ext_from_q32(coef_s12);
		ae = ext_from_q32(coef_ae);
		af = ext_from_q32(coef_af);
		t = ext_add(ext_mul(s12, i12), ext_neg(ext_mul(ae, i6)));
		res.energy = ext_to_q32(ext_mul(ee, t), sat);
		t = ext_add(ext_mul(af, i7), ext_neg(ext_mul(s12, i13)));
		res.force_res = ext_to_q32(ext_mul(ff, t), sat);
		t = ext_add(ext_mul(ext_mul(s12, i14), ext_norm(0, 64'd13, 0)),
			ext_neg(ext_mul(ext_mul(af, i8), ext_norm(0, 64'd7, 0))));
		t = ext_mul(ext_mul(t, ext_norm(0, 64'd12, 0)), ee);
		res.curvature = ext_to_q32(t, sat);
		res.sat = sat;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Result checking: the receiver cannot stall, so every done cycle is
	// a result transaction and is compared against the oldest prediction.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pair_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, energy %h force %h curvature %h",
					$time, energy, force_res, curvature);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (energy !== exp_res.energy) begin
					$display("%0t: energy expected %h actual %h", $time, exp_res.energy,
						energy);
					errors++;
				end
				if (force_res !== exp_res.force_res) begin
					$display("%0t: force_res expected %h actual %h", $time,
						exp_res.force_res, force_res);
					errors++;
				end
				if (curvature !== exp_res.curvature) begin
					$display("%0t: curvature expected %h actual %h", $time,
						exp_res.curvature, curvature);
					errors++;
				end
				if (beyond_cutoff !== exp_res.beyond) begin
					$display("%0t: beyond_cutoff expected %b actual %b", $time,
						exp_res.beyond, beyond_cutoff);
					errors++;
				end
				if (saturated !== exp_res.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, exp_res.sat,
						saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog: any accepted transaction on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers.
	// ---------------------------------------------------------------

	// Offers one distance after a random gap and records its prediction at
	// the edge that accepts the transaction. start is left high so that a
	// following item with no gap keeps the line asserted.
	task automatic send_distance(input bit [31:0] d);
		int gap;
		gap = $urandom_range(0, 12);
		// At least a third of the items go back to back to keep full-rate stretches.
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		distance <= d;
		do @(posedge clk); while (busy);
		pending_results = {pending_results, lj_pair_eval(d)};
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write; only issued once the pipeline is empty. cfg_valid is
	// left high so that writes can follow each other; the caller drops it.
	task automatic write_reg(input cfg_idx_t idx, input bit [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CUTOFF: cut_r = value[31:0];
			CFG_ESCALE: coef_e = value;
			CFG_FSCALE: coef_f = value;
			CFG_REPULS: coef_s12 = value;
			CFG_ATTR_E: coef_ae = value;
			CFG_ATTR_F: coef_af = value;
			default: ;
		endcase
	endtask

	task automatic load_coefs(input bit [31:0] cut, input bit [63:0] e, input bit [63:0] f,
		input bit [63:0] s12, input bit [63:0] ae, input bit [63:0] af);
		wait_drained();
		write_reg(CFG_CUTOFF, {32'd0, cut});
		write_reg(CFG_ESCALE, e);
		write_reg(CFG_FSCALE, f);
		write_reg(CFG_REPULS, s12);
		write_reg(CFG_ATTR_E, ae);
		write_reg(CFG_ATTR_F, af);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// ---------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------

	// With all registers at their reset value only a zero separation is
	// inside the cutoff; it yields zeros but is still flagged.
	task automatic test_reset_state();
		send_distance(32'd0);
		send_distance(32'd1);
		send_distance(32'hFFFF_FFFF);
	endtask

	// Coefficients with doubled attraction terms, then the textbook set with eps = 1 and sigma = 1.
	task automatic test_plain_and_nimn();
		bit [31:0] pts[6];
		pts = '{32'h00E6_6666, ONE_Q24, 32'h011F_5C29, 32'h0180_0000, 32'h0200_0000,
			32'h0280_0000};
		load_coefs(32'h0280_0000, 4 * ONE_Q32, 48 * ONE_Q32, ONE_Q32, 2 * ONE_Q32,
			ONE_Q32);
		foreach (pts[i]) send_distance(pts[i]);
		load_coefs(32'h0280_0000, 4 * ONE_Q32, 48 * ONE_Q32, ONE_Q32, ONE_Q32,
			ONE_Q32 >> 1);
		foreach (pts[i]) send_distance(pts[i]);
	endtask

	// Cutoff boundary, zero distance and the field extremes under a cutoff
	// that admits every separation.
	task automatic test_cutoff_and_extremes();
		load_coefs(32'h0300_0000, 4 * ONE_Q32, 48 * ONE_Q32, ONE_Q32, 2 * ONE_Q32,
			ONE_Q32);
		send_distance(32'h0300_0000);
		send_distance(32'h0300_0001);
		send_distance(32'h02FF_FFFF);
		load_coefs(32'hFFFF_FFFF, 4 * ONE_Q32, 48 * ONE_Q32, ONE_Q32, 2 * ONE_Q32,
			ONE_Q32);
		send_distance(32'd0);
		send_distance(32'd1);
		send_distance(32'hFFFF_FFFF);
		send_distance(32'h8000_0000);
	endtask

	// Most positive and most negative coefficients drive results into
	// clipping of both signs; unknown register indexes must be ignored.
	task automatic test_saturation();
		load_coefs(32'hFFFF_FFFF, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		wait_drained();
		write_reg(cfg_idx_t'(3'd6), rand64());
		write_reg(cfg_idx_t'(3'd7), rand64());
		cfg_valid <= 1'b0;
		send_distance(32'h0000_8000);
		send_distance(ONE_Q24);
		send_distance(32'h4000_0000);
		load_coefs(32'hFFFF_FFFF, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send_distance(32'h0000_8000);
		send_distance(ONE_Q24);
		send_distance(32'hFFFF_FFFF);
	endtask

	// Random phases: each picks a coefficient set, then streams distances
	// that are mostly physical with some anywhere in the 32-bit range.
	task automatic test_random_phases();
		bit [31:0] cut, d;
		bit [63:0] eps, sig6;
		int        kind;
		for (int ph = 0; ph < 10; ph++) begin
			kind = $urandom_range(0, 3);
			eps = 64'($urandom_range(1, 1 << 20)) << 12;
			sig6 = 64'($urandom_range(1, 1 << 24)) << 8;
			case (ph)
				0: cut = 32'd0;
				1: cut = 32'hFFFF_FFFF;
				default: cut = $urandom_range(32'h0080_0000, 32'h0400_0000);
			endcase
			if (kind == 0) begin
				load_coefs(cut, rand64(), rand64(), rand64(), rand64(), rand64());
			end else begin
				load_coefs(cut, eps << 2, eps * 48, (sig6 * sig6) >> 32,
					(kind == 1) ? sig6 << 1 : sig6, (kind == 1) ? sig6 : sig6 >> 1);
			end
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					d = $urandom_range(32'h0080_0000, 32'h0400_0000);
				end else begin
					d = $urandom;
				end
				send_distance(d);
				// Once per phase the sender holds off until the pipeline is empty.
				if (n == 30) wait_drained();
			end
		end
	endtask

	initial begin
		cut_r = '0;
		coef_e = '0;
		coef_f = '0;
		coef_s12 = '0;
		coef_ae = '0;
		coef_af = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_plain_and_nimn();
		test_cutoff_and_extremes();
		test_saturation();
		test_random_phases();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
